/* design/lbhs_pkg.sv */
`default_nettype none

package lbhs_pkg;

    // Smallest end offset that a ceiling scan with a size budget may use, unless the segment is smaller.
    localparam int unsigned MIN_CEILING_SPAN = 8192;

    // Command codes of an input item.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // Scan modes.
    localparam logic MODE_CEILING = 1'b0;
    localparam logic MODE_START   = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_STOPPED   = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_NO_ADJUST = 2'd2;

    // Flag byte layout.
    localparam int unsigned SPARSE_BIT = 6;
    localparam int unsigned COUNT_LSB  = 2;
    localparam int unsigned COUNT_MSB  = 5;

    // A varint carries at most this many continuation bytes past the first.
    localparam logic [2:0] VARINT_LAST = 3'd4;
    // The first sequence number field is eight bytes, little endian.
    localparam logic [2:0] FIRST_LAST  = 3'd7;

    // Budget value that disables the size budget.
    localparam logic [31:0] NO_BUDGET = 32'hffff_ffff;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
        logic        scan_mode;
        logic [31:0] start_offset;
        logic [63:0] start_seqnum;
        logic [63:0] target_seqnum;
        logic [31:0] seg_size;
        logic [31:0] size_budget;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_offset;
        logic [63:0] result_seqnum;
        logic        sparse_bundle;
        logic [1:0]  scan_status;
    } t_out_item;

    // Response of the scan core for the item it processes this cycle.
    typedef struct packed {
        logic      emit;
        logic      busy;
        t_out_item item;
    } t_core_resp;

    // Merges one varint byte into the accumulator; bits past 32 drop.
    function automatic logic [31:0] varint_merge(input logic [31:0] acc,
                                                 input logic [7:0]  b,
                                                 input logic [2:0]  shift);
        logic [31:0] res;
        case (shift)
            3'd0:    res = acc | {25'd0, b[6:0]};
            3'd1:    res = acc | {18'd0, b[6:0], 7'd0};
            3'd2:    res = acc | {11'd0, b[6:0], 14'd0};
            3'd3:    res = acc | {4'd0, b[6:0], 21'd0};
            3'd4:    res = acc | {b[3:0], 28'd0};
            default: res = acc;
        endcase
        return res;
    endfunction

    // A varint ends on a byte without continuation bit or after five bytes.
    function automatic logic varint_done(input logic [7:0] b,
                                         input logic [2:0] shift);
        return !b[7] || (shift >= VARINT_LAST);
    endfunction

endpackage

`default_nettype wire

/* design/lbhs_in_if.sv */
`default_nettype none

interface lbhs_in_if;
    import lbhs_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/lbhs_out_if.sv */
`default_nettype none

interface lbhs_out_if;
    import lbhs_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/lbhs_scan_core.sv */
`default_nettype none

module lbhs_scan_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire lbhs_pkg::t_in_item i_item,
    output lbhs_pkg::t_core_resp    o_resp
);
    import lbhs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_FLAGS,
        PH_COUNT,
        PH_FIRST,
        PH_DELTA,
        PH_SKIP
    } t_phase;

    t_phase      r_phase,      n_phase;
    logic [31:0] r_cur_offset, n_cur_offset;
    logic [31:0] r_limit,      n_limit;
    logic [31:0] r_file_end,   n_file_end;
    logic [63:0] r_run_seq,    n_run_seq;
    logic [63:0] r_target,     n_target;
    logic        r_mode,       n_mode;
    logic [31:0] r_vacc,       n_vacc;
    logic [2:0]  r_vshift,     n_vshift;
    logic [31:0] r_blen,       n_blen;
    logic [2:0]  r_lbytes,     n_lbytes;
    logic [7:0]  r_flag,       n_flag;
    logic [31:0] r_mcount,     n_mcount;
    logic [63:0] r_first,      n_first;
    logic [31:0] r_skip,       n_skip;
    logic        r_sparse,     n_sparse;
    logic [31:0] r_orig_off,   n_orig_off;
    logic [63:0] r_orig_seq,   n_orig_seq;

    t_out_item   w_item;
    logic        w_emit;

    // Next state and result for the item processed this cycle.
    always_comb begin
        logic        do_after;
        logic        do_fin;
        logic        do_start;
        logic        sparse;
        logic        stop;
        logic        short_tail;
        logic [7:0]  b;
        logic [31:0] acc;
        logic [31:0] delta;
        logic [31:0] lim;
        logic [63:0] next_seq;

        n_phase      = r_phase;
        n_cur_offset = r_cur_offset;
        n_limit      = r_limit;
        n_file_end   = r_file_end;
        n_run_seq    = r_run_seq;
        n_target     = r_target;
        n_mode       = r_mode;
        n_vacc       = r_vacc;
        n_vshift     = r_vshift;
        n_blen       = r_blen;
        n_lbytes     = r_lbytes;
        n_flag       = r_flag;
        n_mcount     = r_mcount;
        n_first      = r_first;
        n_skip       = r_skip;
        n_sparse     = r_sparse;
        n_orig_off   = r_orig_off;
        n_orig_seq   = r_orig_seq;

        w_emit     = 1'b0;
        w_item     = '0;
        do_after   = 1'b0;
        do_fin     = 1'b0;
        do_start   = 1'b0;
        sparse     = 1'b0;
        stop       = 1'b0;
        short_tail = 1'b0;
        b          = i_item.data_byte;
        acc        = varint_merge(r_vacc, b, r_vshift);
        delta      = '0;
        lim        = '0;
        next_seq   = '0;

        if (i_item.cmd == CMD_START) begin
            // Set up a new scan; any running scan is dropped.
            n_mode       = i_item.scan_mode;
            n_cur_offset = i_item.start_offset;
            n_orig_off   = i_item.start_offset;
            n_run_seq    = i_item.start_seqnum;
            n_orig_seq   = i_item.start_seqnum;
            n_target     = i_item.target_seqnum;
            n_file_end   = i_item.seg_size;
            n_sparse     = 1'b0;
            n_skip       = '0;
            if (i_item.scan_mode == MODE_CEILING && i_item.size_budget != NO_BUDGET) begin
                lim = i_item.start_offset + i_item.size_budget;
                if (lim < 32'(MIN_CEILING_SPAN)) begin
                    lim = 32'(MIN_CEILING_SPAN);
                end
                if (lim > i_item.seg_size) begin
                    lim = i_item.seg_size;
                end
                n_limit = lim;
            end else begin
                n_limit = i_item.seg_size;
            end
            if (i_item.scan_mode == MODE_START &&
                (i_item.target_seqnum == i_item.start_seqnum ||
                 i_item.target_seqnum <= 64'd1)) begin
                w_emit = 1'b1;
                w_item = '{i_item.start_offset, i_item.start_seqnum, 1'b0, ST_NO_ADJUST};
            end else begin
                do_start = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_LEN: begin
                    n_lbytes = r_lbytes + 3'd1;
                    n_vacc   = acc;
                    if (varint_done(b, r_vshift)) begin
                        n_blen  = acc;
                        n_skip  = acc;
                        n_phase = PH_FLAGS;
                    end else begin
                        n_vshift = r_vshift + 3'd1;
                    end
                end
                PH_FLAGS: begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - 32'd1;
                    end
                    n_flag = b;
                    if (b[COUNT_MSB:COUNT_LSB] != '0) begin
                        n_mcount = {28'd0, b[COUNT_MSB:COUNT_LSB]};
                        do_after = 1'b1;
                    end else begin
                        n_phase  = PH_COUNT;
                        n_vacc   = '0;
                        n_vshift = '0;
                    end
                end
                PH_COUNT: begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - 32'd1;
                    end
                    n_vacc = acc;
                    if (varint_done(b, r_vshift)) begin
                        n_mcount = acc;
                        do_after = 1'b1;
                    end else begin
                        n_vshift = r_vshift + 3'd1;
                    end
                end
                PH_FIRST: begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - 32'd1;
                    end
                    n_first = r_first | ({56'd0, b} << {r_vshift, 3'b000});
                    if (r_vshift >= FIRST_LAST) begin
                        if (r_mcount != 32'd1) begin
                            n_phase  = PH_DELTA;
                            n_vacc   = '0;
                            n_vshift = '0;
                        end else begin
                            do_fin = 1'b1;
                        end
                    end else begin
                        n_vshift = r_vshift + 3'd1;
                    end
                end
                PH_DELTA: begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - 32'd1;
                    end
                    n_vacc = acc;
                    if (varint_done(b, r_vshift)) begin
                        do_fin = 1'b1;
                        delta  = acc;
                    end else begin
                        n_vshift = r_vshift + 3'd1;
                    end
                end
                PH_SKIP: begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - 32'd1;
                    end
                    if (n_skip == '0) begin
                        do_start = 1'b1;
                    end
                end
                default: begin
                    // Bytes with no scan running are dropped.
                end
            endcase
        end

        // After the message count: sparse bundles carry a first sequence number.
        if (do_after) begin
            if (n_flag[SPARSE_BIT]) begin
                n_phase  = PH_FIRST;
                n_first  = '0;
                n_vshift = '0;
            end else begin
                do_fin = 1'b1;
            end
        end

        // Header complete: stop here or move past the bundle.
        if (do_fin) begin
            sparse   = n_flag[SPARSE_BIT];
            n_sparse = sparse;
            if (sparse) begin
                next_seq = (n_mcount != 32'd1) ? n_first + {32'd0, delta} + 64'd2
                                               : n_first + 64'd1;
            end else begin
                next_seq = r_run_seq + {32'd0, n_mcount};
            end
            if (r_mode == MODE_CEILING) begin
                stop = r_run_seq > r_target;
            end else begin
                stop = r_target < next_seq;
            end
            if (stop) begin
                w_emit = 1'b1;
                w_item = '{r_cur_offset, r_run_seq, sparse, ST_STOPPED};
            end else begin
                n_run_seq    = next_seq;
                n_cur_offset = r_cur_offset + r_blen + {29'd0, r_lbytes};
                if (n_skip != '0) begin
                    n_phase = PH_SKIP;
                end else begin
                    do_start = 1'b1;
                end
            end
        end

        // Start of a bundle: check the limit and, in ceiling mode, the short tail.
        if (do_start) begin
            if (n_cur_offset < n_limit && n_mode == MODE_CEILING) begin
                short_tail = (n_file_end - n_cur_offset) < 32'd4;
            end
            if (n_cur_offset >= n_limit || short_tail) begin
                w_emit = 1'b1;
                if (n_mode == MODE_START) begin
                    w_item = '{n_orig_off, n_orig_seq, n_sparse, ST_LIMIT};
                end else begin
                    w_item = '{n_cur_offset, n_run_seq, n_sparse, ST_LIMIT};
                end
            end else begin
                n_phase  = PH_LEN;
                n_lbytes = '0;
                n_vacc   = '0;
                n_vshift = '0;
            end
        end

        if (w_emit) begin
            n_phase = PH_IDLE;
        end
    end

    // Scan state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_cur_offset <= '0;
            r_limit      <= '0;
            r_file_end   <= '0;
            r_run_seq    <= '0;
            r_target     <= '0;
            r_mode       <= 1'b0;
            r_vacc       <= '0;
            r_vshift     <= '0;
            r_blen       <= '0;
            r_lbytes     <= '0;
            r_flag       <= '0;
            r_mcount     <= '0;
            r_first      <= '0;
            r_skip       <= '0;
            r_sparse     <= 1'b0;
            r_orig_off   <= '0;
            r_orig_seq   <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_cur_offset <= n_cur_offset;
            r_limit      <= n_limit;
            r_file_end   <= n_file_end;
            r_run_seq    <= n_run_seq;
            r_target     <= n_target;
            r_mode       <= n_mode;
            r_vacc       <= n_vacc;
            r_vshift     <= n_vshift;
            r_blen       <= n_blen;
            r_lbytes     <= n_lbytes;
            r_flag       <= n_flag;
            r_mcount     <= n_mcount;
            r_first      <= n_first;
            r_skip       <= n_skip;
            r_sparse     <= n_sparse;
            r_orig_off   <= n_orig_off;
            r_orig_seq   <= n_orig_seq;
        end
    end

    assign o_resp.emit = w_emit;
    assign o_resp.busy = (r_phase != PH_IDLE);
    assign o_resp.item = w_item;

endmodule

`default_nettype wire

/* design/log_bundle_header_scanner.sv */
// Path: the input register holds the accepted item, then the scan logic writes
// the result it causes into the result register, from which it is taken.
// Throughput: one item per cycle; the scan logic takes a byte in every cycle
// in which the result register is empty or being drained.
// Reset: synchronous, active low; clears the scan state to idle and empties both registers.
`default_nettype none

module log_bundle_header_scanner (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lbhs_in_if.sink     i_in,
    lbhs_out_if.source  o_out
);
    import lbhs_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    logic       w_fire;
    t_core_resp w_resp;

    // The scan logic takes the held item when the result register can take a result.
    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
    end

    lbhs_scan_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in_item),
        .o_resp  (w_resp)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_resp.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_resp.emit) begin
            r_out_item <= w_resp.item;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    // A result ends the scan.
    a_emit_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_resp.emit) |=> !w_resp.busy)
        else $error("scan still busy after a result");

    // A result always lands in the result register.
    a_emit_registered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_resp.emit) |=> r_out_valid)
        else $error("result lost");

    // A held input transaction is not dropped while the scan logic stalls.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_in_item)))
        else $error("held input transaction lost");

    // Only defined status codes reach the output.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.scan_status == ST_STOPPED ||
                         r_out_item.scan_status == ST_LIMIT ||
                         r_out_item.scan_status == ST_NO_ADJUST))
        else $error("undefined scan status");

endmodule

`default_nettype wire

/* bench/log_bundle_header_scanner_tb.sv */
`default_nettype none

module log_bundle_header_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbhs_pkg::*;

    localparam int unsigned ITEM_COUNT   = 1850;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Parse phases of the scan, as the block walks through a bundle header.
    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_LEN,
        SCAN_FLAGS,
        SCAN_COUNT,
        SCAN_FIRST,
        SCAN_DELTA,
        SCAN_SKIP
    } t_scan_phase;

    logic clk = 1'b0;
    logic rst_n;

    lbhs_in_if  in_ch ();
    lbhs_out_if out_ch ();

    log_bundle_header_scanner i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Scan state of the predictor, at its reset values.
    t_scan_phase scan_phase  = SCAN_IDLE;
    logic [31:0] cur_off     = '0;
    logic [31:0] limit_off   = '0;
    logic [31:0] file_end    = '0;
    logic [63:0] run_seq     = '0;
    logic [63:0] target_seq  = '0;
    logic        mode_sel    = MODE_CEILING;
    logic [31:0] vacc        = '0;
    logic [2:0]  vshift      = '0;
    logic [31:0] blen        = '0;
    logic [2:0]  len_bytes   = '0;
    logic [7:0]  flag_bits   = '0;
    logic [31:0] msg_count   = '0;
    logic [63:0] first_seq   = '0;
    logic [31:0] skip_left   = '0;
    logic        last_sparse = 1'b0;
    logic [31:0] orig_off    = '0;
    logic [63:0] orig_seq    = '0;

    t_out_item   scan_answer;
    t_out_item   pending_answers [$];
    logic [7:0]  stream_bytes [$];

    int          fail_count  = 0;
    int          live_items  = 0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          hold_asked  = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int unsigned cycle_count = 0;

    // Clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** log_bundle_header_scanner: FAILED **");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Every result transaction is compared with the oldest predicted answer.
    always @(posedge clk) begin : check_results
        t_out_item want;
        bit        bad;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, out_ch.data);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                bad = 1'b0;
                if (out_ch.data.result_offset !== want.result_offset) begin
                    $display("%0t: result_offset expected %h actual %h",
                             $time, want.result_offset, out_ch.data.result_offset);
                    bad = 1'b1;
                end
                if (out_ch.data.result_seqnum !== want.result_seqnum) begin
                    $display("%0t: result_seqnum expected %h actual %h",
                             $time, want.result_seqnum, out_ch.data.result_seqnum);
                    bad = 1'b1;
                end
                if (out_ch.data.sparse_bundle !== want.sparse_bundle) begin
                    $display("%0t: sparse_bundle expected %b actual %b",
                             $time, want.sparse_bundle, out_ch.data.sparse_bundle);
                    bad = 1'b1;
                end
                if (out_ch.data.scan_status !== want.scan_status) begin
                    $display("%0t: scan_status expected %0d actual %0d",
                             $time, want.scan_status, out_ch.data.scan_status);
                    bad = 1'b1;
                end
                if (bad)
                    fail_count++;
            end
        end
    end

    // Predictor: records the answer and returns the scan to idle.
    function automatic bit finish_scan(input logic [31:0] off, input logic [63:0] seq,
                                       input logic sp, input logic [1:0] st);
        scan_answer.result_offset = off;
        scan_answer.result_seqnum = seq;
        scan_answer.sparse_bundle = sp;
        scan_answer.scan_status   = st;
        scan_phase = SCAN_IDLE;
        return 1'b1;
    endfunction

    // Predictor: a new bundle begins at cur_off, unless the limit is reached.
    function automatic bit open_bundle();
        logic short_tail;
        short_tail = 1'b0;
        if (cur_off < limit_off && mode_sel == MODE_CEILING)
            short_tail = (file_end - cur_off) < 32'd4;
        if (cur_off >= limit_off || short_tail) begin
            if (mode_sel == MODE_START)
                return finish_scan(orig_off, orig_seq, last_sparse, ST_LIMIT);
            return finish_scan(cur_off, run_seq, last_sparse, ST_LIMIT);
        end
        scan_phase = SCAN_LEN;
        len_bytes = '0;
        vacc = '0;
        vshift = '0;
        return 1'b0;
    endfunction

    // Predictor: adds one varint byte; true when the varint is complete.
    function automatic bit varint_take(input logic [7:0] b);
        logic [31:0] part;
        part = {25'd0, b[6:0]} << (7 * vshift);
        if (vshift <= VARINT_LAST)
            vacc = vacc | part;
        if (!b[7] || vshift >= VARINT_LAST)
            return 1'b1;
        vshift = vshift + 3'd1;
        return 1'b0;
    endfunction

    // Predictor: header complete; either stop here or move past the bundle.
    function automatic bit close_header(input logic [31:0] delta);
        logic        sp;
        logic        stop;
        logic [63:0] next_seq;
        sp = flag_bits[SPARSE_BIT];
        last_sparse = sp;
        if (sp)
            next_seq = (msg_count != 32'd1) ? first_seq + {32'd0, delta} + 64'd2
                                            : first_seq + 64'd1;
        else
            next_seq = run_seq + {32'd0, msg_count};
        stop = (mode_sel == MODE_CEILING) ? (run_seq > target_seq)
                                          : (target_seq < next_seq);
        if (stop)
            return finish_scan(cur_off, run_seq, sp, ST_STOPPED);
        run_seq = next_seq;
        cur_off = cur_off + blen + {29'd0, len_bytes};
        if (skip_left != 0) begin
            scan_phase = SCAN_SKIP;
            return 1'b0;
        end
        return open_bundle();
    endfunction

    // Predictor: message count known; a sparse bundle still has its first seqnum.
    function automatic bit count_known();
        if (flag_bits[SPARSE_BIT]) begin
            scan_phase = SCAN_FIRST;
            first_seq = '0;
            vshift = '0;
            return 1'b0;
        end
        return close_header('0);
    endfunction

    // Predictor: one accepted input transaction; true when it causes a result.
    function automatic bit scan_step(input t_in_item it);
        logic [31:0] lim;
        logic [7:0]  b;
        b = it.data_byte;
        if (it.cmd == CMD_START) begin
            mode_sel    = it.scan_mode;
            cur_off     = it.start_offset;
            orig_off    = it.start_offset;
            run_seq     = it.start_seqnum;
            orig_seq    = it.start_seqnum;
            target_seq  = it.target_seqnum;
            file_end    = it.seg_size;
            last_sparse = 1'b0;
            skip_left   = '0;
            if (mode_sel == MODE_CEILING && it.size_budget != NO_BUDGET) begin
                lim = it.start_offset + it.size_budget;
                if (lim < MIN_CEILING_SPAN)
                    lim = MIN_CEILING_SPAN;
                if (lim > it.seg_size)
                    lim = it.seg_size;
                limit_off = lim;
            end else begin
                limit_off = it.seg_size;
            end
            if (mode_sel == MODE_START && (target_seq == run_seq || target_seq <= 64'd1))
                return finish_scan(it.start_offset, run_seq, 1'b0, ST_NO_ADJUST);
            return open_bundle();
        end
        // Header bytes after the length also count against the bundle length.
        if (scan_phase inside {SCAN_FLAGS, SCAN_COUNT, SCAN_FIRST, SCAN_DELTA}
                && skip_left != 0)
            skip_left = skip_left - 1;
        case (scan_phase)
            SCAN_LEN: begin
                len_bytes = len_bytes + 3'd1;
                if (varint_take(b)) begin
                    blen = vacc;
                    skip_left = vacc;
                    scan_phase = SCAN_FLAGS;
                end
            end
            SCAN_FLAGS: begin
                flag_bits = b;
                if (b[COUNT_MSB:COUNT_LSB] != 4'd0) begin
                    msg_count = {28'd0, b[COUNT_MSB:COUNT_LSB]};
                    return count_known();
                end
                scan_phase = SCAN_COUNT;
                vacc = '0;
                vshift = '0;
            end
            SCAN_COUNT: begin
                if (varint_take(b)) begin
                    msg_count = vacc;
                    return count_known();
                end
            end
            SCAN_FIRST: begin
                first_seq = first_seq | ({56'd0, b} << (8 * vshift));
                if (vshift >= FIRST_LAST) begin
                    if (msg_count != 32'd1) begin
                        scan_phase = SCAN_DELTA;
                        vacc = '0;
                        vshift = '0;
                        return 1'b0;
                    end
                    return close_header('0);
                end
                vshift = vshift + 3'd1;
            end
            SCAN_DELTA: begin
                if (varint_take(b))
                    return close_header(vacc);
            end
            SCAN_SKIP: begin
                if (skip_left != 0)
                    skip_left = skip_left - 1;
                if (skip_left == 0)
                    return open_bundle();
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Start transaction; the byte field is don't-care and gets noise.
    function automatic t_in_item start_item(input logic mode, input logic [31:0] start,
                                            input logic [63:0] seq, input logic [63:0] target,
                                            input logic [31:0] fsize, input logic [31:0] budget);
        t_in_item it;
        it.cmd           = CMD_START;
        it.data_byte     = 8'($urandom);
        it.scan_mode     = mode;
        it.start_offset  = start;
        it.start_seqnum  = seq;
        it.target_seqnum = target;
        it.seg_size      = fsize;
        it.size_budget   = budget;
        return it;
    endfunction

    // File byte transaction; the set-up fields are don't-care and get noise.
    function automatic t_in_item byte_item(input logic [7:0] b);
        t_in_item it;
        it.cmd           = CMD_BYTE;
        it.data_byte     = b;
        it.scan_mode     = 1'($urandom);
        it.start_offset  = $urandom;
        it.start_seqnum  = {$urandom, $urandom};
        it.target_seqnum = {$urandom, $urandom};
        it.seg_size      = $urandom;
        it.size_budget   = $urandom;
        return it;
    endfunction

    function automatic int varint_size(input logic [31:0] v, input bit pad);
        if (pad || v >= 32'h1000_0000)
            return 5;
        if (v >= 32'h0020_0000)
            return 4;
        if (v >= 32'h0000_4000)
            return 3;
        if (v >= 32'h0000_0080)
            return 2;
        return 1;
    endfunction

    // Appends a varint to the byte stream. A five-byte form carries noise in
    // the bits of its last byte that the decoder must drop.
    function automatic void push_varint(input logic [31:0] v, input bit pad);
        int         n;
        logic [7:0] b;
        n = varint_size(v, pad);
        for (int i = 0; i < n - 1; i++)
            stream_bytes.push_back({1'b1, v[7*i +: 7]});
        if (n == 5) begin
            b = 8'($urandom);
            b[3:0] = v[31:28];
        end else begin
            b = {1'b0, v[7*(n-1) +: 7]};
        end
        stream_bytes.push_back(b);
    endfunction

    // Offers one transaction, waits for the handshake, then predicts it.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (it.cmd == CMD_START || scan_phase != SCAN_IDLE)
            live_items++;
        if (scan_step(it))
            pending_answers.push_back(scan_answer);
    endtask

    // Stops offering transactions and waits until every answer has come back.
    task automatic wait_for_answers();
        in_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // Start mode with nothing to adjust: target 0, target 1, target at the base.
    task automatic test_no_adjust();
        send_item(start_item(MODE_START, 32'h0000_0000, 64'd77, 64'd0,
                             32'hffff_ffff, 32'h0000_0000));
        send_item(start_item(MODE_START, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 64'd1,
                             32'h0000_0000, NO_BUDGET));
        send_item(start_item(MODE_START, 32'h8000_0000, 64'h8000_0000_0000_0000,
                             64'h8000_0000_0000_0000, 32'h8000_0010, 32'h0000_0001));
    endtask

    // Scans that end at once: short tail in ceiling mode, limit in start mode.
    task automatic test_limit_cases();
        send_item(start_item(MODE_CEILING, 32'd100, 64'd5, 64'd1000, 32'd103, NO_BUDGET));
        send_item(start_item(MODE_START, 32'hffff_ffff, 64'd2, 64'd5,
                             32'h0000_0000, 32'hffff_ffff));
    endtask

    // Ceiling scan over three bundles: a padded five-byte length, a bundle
    // shorter than its header with a varint count, and a sparse bundle with
    // an all-ones first seqnum, where the scan stops.
    task automatic test_bundle_walk();
        logic [7:0] walk [0:19] = '{8'h82, 8'h80, 8'h80, 8'h80, 8'hf0, 8'h0c, 8'hff,
                                    8'h01, 8'h80, 8'h05,
                                    8'h09, 8'h44, 8'hff, 8'hff, 8'hff, 8'hff,
                                    8'hff, 8'hff, 8'hff, 8'hff};
        send_item(start_item(MODE_CEILING, 32'h0000_1000, 64'hffff_ffff_ffff_ff00,
                             64'hffff_ffff_ffff_ff05, 32'hffff_ffff, NO_BUDGET));
        foreach (walk[i])
            send_item(byte_item(walk[i]));
    endtask

    // The result side holds off while start transactions keep coming, so the
    // block fills up and must stall its input.
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_asked++;
        repeat (24)
            send_item(start_item(MODE_START, $urandom, {$urandom, $urandom}, 64'd0,
                                 $urandom, $urandom));
        wait_for_answers();
    endtask

    // One random scan: mostly a well-formed bundle stream, sometimes noise.
    task automatic random_scan();
        logic [63:0] base, seq, first, target;
        logic [31:0] start, fsize, budget, span, flen, delta;
        logic [7:0]  flags;
        logic        mode;
        int          nb, cnt, hdr, len;
        bit          sparse, in_flags, pad;
        if ($urandom_range(0, 9) == 0) begin
            send_item(start_item(1'($urandom_range(0, 1)), $urandom, {$urandom, $urandom},
                                 {$urandom, $urandom}, $urandom, $urandom));
            repeat ($urandom_range(1, 24))
                send_item(byte_item(8'($urandom)));
            return;
        end

        // Build the bundle stream and track the sequence numbers it implies.
        stream_bytes.delete();
        if ($urandom_range(0, 1) == 1)
            base = {$urandom, $urandom};
        else
            base = {32'd0, $urandom_range(0, 1000)};
        seq = base;
        nb = $urandom_range(1, 6);
        for (int i = 0; i < nb; i++) begin
            sparse   = ($urandom_range(0, 3) == 0);
            in_flags = ($urandom_range(0, 9) < 7);
            cnt      = in_flags ? $urandom_range(1, 15) : $urandom_range(0, 40);
            pad      = ($urandom_range(0, 9) == 0);
            first    = seq + $urandom_range(0, 2);
            delta    = $urandom_range(0, 20);
            hdr = 1 + (in_flags ? 0 : varint_size(cnt, pad))
                    + (sparse ? 8 + ((cnt != 1) ? varint_size(delta, 1'b0) : 0) : 0);
            // Now and then a bundle whose length is shorter than its header.
            if ($urandom_range(0, 11) == 0)
                len = $urandom_range(0, hdr - 1);
            else
                len = hdr + $urandom_range(0, 5);
            push_varint(len, $urandom_range(0, 9) == 0);
            flags = 8'($urandom);
            flags[SPARSE_BIT] = sparse;
            flags[COUNT_MSB:COUNT_LSB] = in_flags ? cnt[3:0] : 4'd0;
            stream_bytes.push_back(flags);
            if (!in_flags)
                push_varint(cnt, pad);
            if (sparse) begin
                for (int k = 0; k < 8; k++)
                    stream_bytes.push_back(first[8*k +: 8]);
                if (cnt != 1)
                    push_varint(delta, 1'b0);
            end
            if (len > hdr)
                repeat (len - hdr)
                    stream_bytes.push_back(8'($urandom));
            if (!sparse)
                seq = seq + cnt;
            else
                seq = (cnt != 1) ? first + delta + 64'd2 : first + 64'd1;
        end

        // Set-up: mode, offsets, target and limits around the stream.
        mode = 1'($urandom_range(0, 1));
        flen = stream_bytes.size();
        span = 32'(seq - base);
        case ($urandom_range(0, 2))
            0:       start = $urandom_range(0, 100);
            1:       start = $urandom_range(8000, 20000);
            default: start = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0:       target = {$urandom, $urandom};
            1:       target = {32'd0, $urandom_range(0, 1)};
            default: target = base + $urandom_range(0, span + 3);
        endcase
        case ($urandom_range(0, 9))
            0, 1:    fsize = $urandom;
            2, 3, 4: fsize = start + $urandom_range(0, flen);
            default: fsize = start + flen + $urandom_range(0, 8);
        endcase
        case ($urandom_range(0, 4))
            0, 1:    budget = NO_BUDGET;
            2:       budget = $urandom;
            default: budget = $urandom_range(0, flen + 10);
        endcase

        send_item(start_item(mode, start, base, target, fsize, budget));
        foreach (stream_bytes[i]) begin
            if (scan_phase == SCAN_IDLE)
                break;
            send_item(byte_item(stream_bytes[i]));
        end
        // Stray bytes after the scan has ended are ignored by the block.
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3))
                send_item(byte_item(8'($urandom)));
    endtask

    task automatic test_random_scans(input int send_gap_pct, input int recv_stall_pct,
                                     input int count);
        idle_pct = send_gap_pct;
        stall_pct = recv_stall_pct;
        live_items = 0;
        while (live_items < count)
            random_scan();
    endtask

    // Test sequence.
    initial begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_adjust();
        test_limit_cases();
        test_bundle_walk();
        test_backpressure();
        test_random_scans(0, 0, ITEM_COUNT / 4);
        test_random_scans(51, 0, ITEM_COUNT / 4);
        test_random_scans(0, 51, ITEM_COUNT / 4);
        test_random_scans(34, 34, ITEM_COUNT / 4);

        wait_for_answers();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("** log_bundle_header_scanner: PASSED **");
        else
            $display("** log_bundle_header_scanner: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
